/* sv/tbce_pkg.sv */
package tbce_pkg;

   localparam int CAPACITY   = 1024;
   localparam int ADDR_W     = $clog2(CAPACITY);
   localparam int POS_W      = ADDR_W + 1;
   localparam int AMT_W      = 12;
   localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [7:0] LINE_WIDTH_RESET = 8'd80;

   localparam logic [2:0] OP_OVERWRITE = 3'd0;
   localparam logic [2:0] OP_INSERT    = 3'd1;
   localparam logic [2:0] OP_DELETE    = 3'd2;
   localparam logic [2:0] OP_MOVE_REL  = 3'd3;
   localparam logic [2:0] OP_MOVE_ABS  = 3'd4;
   localparam logic [2:0] OP_RECOUNT   = 3'd5;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_REFUSED = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECIDE,
      S_INS_RD,
      S_INS_WR,
      S_DEL_RD,
      S_DEL_WR,
      S_WALK_RD,
      S_WALK_ADV,
      S_RESPOND
   } state_type;

   // what the controller asks of the datapath in one cycle
   typedef struct packed {
      logic latch_req;    // capture the request and evaluate checks
      logic ov_commit;    // overwrite: write store, bump cursor, extend length, advance view
      logic ins_setup;    // pointer = length
      logic ins_rd;       // read entry pointer-1
      logic ins_wr;       // write read data at pointer, pointer--
      logic ins_commit;   // write char at cursor, cursor++, length++, view
      logic del_setup;    // pointer = cursor, read removed char
      logic del_rd;       // read entry pointer+1
      logic del_wr;       // write at pointer, pointer++
      logic del_commit;   // length--
      logic walk_setup;   // set walk range, maybe clear view
      logic walk_rd;      // read entry pointer
      logic walk_adv;     // advance view by read data, pointer++
      logic walk_commit;  // cursor = target (unchanged for recount)
      logic respond;      // present result
   } cmd_type;

   typedef struct packed {
      logic ov_full;
      logic ins_full;
      logic del_bad;
      logic move_bad;
      logic ins_more;    // pointer > cursor
      logic del_more;    // pointer + 1 < length
      logic walk_more;   // pointer < walk end
   } stat_type;

endpackage

/* sv/tbce_ram.sv */
module tbce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* sv/tbce_ctrl.sv */
module tbce_ctrl
   import tbce_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [2:0] op,
   input  stat_type   stat,
   output cmd_type    cmd,
   output logic       busy
);

   state_type state_ff, state_in;
   logic [2:0] op_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (start && state_ff == S_IDLE) begin
         op_ff <= op;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            priority case (op_ff)
               OP_OVERWRITE: state_in = S_RESPOND;
               OP_INSERT:    state_in = stat.ins_full ? S_RESPOND : S_INS_RD;
               OP_DELETE:    state_in = stat.del_bad ? S_RESPOND : S_DEL_RD;
               OP_MOVE_REL,
               OP_MOVE_ABS:  state_in = stat.move_bad ? S_RESPOND : S_WALK_RD;
               OP_RECOUNT:   state_in = S_WALK_RD;
               default:      state_in = S_RESPOND;
            endcase
         end
         S_INS_RD:   state_in = stat.ins_more ? S_INS_WR : S_RESPOND;
         S_INS_WR:   state_in = S_INS_RD;
         S_DEL_RD:   state_in = stat.del_more ? S_DEL_WR : S_RESPOND;
         S_DEL_WR:   state_in = S_DEL_RD;
         S_WALK_RD:  state_in = stat.walk_more ? S_WALK_ADV : S_RESPOND;
         S_WALK_ADV: state_in = S_WALK_RD;
         S_RESPOND:  state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      busy = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: cmd.latch_req = start;
         S_DECIDE: begin
            priority case (op_ff)
               OP_OVERWRITE: cmd.ov_commit = !stat.ov_full;
               OP_INSERT:    cmd.ins_setup = !stat.ins_full;
               OP_DELETE:    cmd.del_setup = !stat.del_bad;
               OP_MOVE_REL,
               OP_MOVE_ABS:  cmd.walk_setup = !stat.move_bad;
               OP_RECOUNT:   cmd.walk_setup = 1'b1;
               default: ;
            endcase
         end
         S_INS_RD: begin
            cmd.ins_rd = stat.ins_more;
            cmd.ins_commit = !stat.ins_more;
         end
         S_INS_WR: cmd.ins_wr = 1'b1;
         S_DEL_RD: begin
            cmd.del_rd = stat.del_more;
            cmd.del_commit = !stat.del_more;
         end
         S_DEL_WR: cmd.del_wr = 1'b1;
         S_WALK_RD: begin
            cmd.walk_rd = stat.walk_more;
            cmd.walk_commit = !stat.walk_more;
         end
         S_WALK_ADV: cmd.walk_adv = 1'b1;
         S_RESPOND: cmd.respond = 1'b1;
         default: ;
      endcase
   end

endmodule

/* sv/tbce_datapath.sv */
module tbce_datapath
   import tbce_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output stat_type                stat,
   input  logic [2:0]              op,
   input  logic [7:0]              char_in,
   input  logic signed [AMT_W-1:0] amount,
   input  logic [7:0]              line_width,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_status,
   output logic [7:0]              rsp_removed_char,
   output logic [10:0]             rsp_cursor_pos,
   output logic [10:0]             rsp_text_length,
   output logic [7:0]              rsp_view_column,
   output logic [15:0]             rsp_view_row,
   output logic signed [11:0]      rsp_displacement
);

   logic [POS_W-1:0] cursor_ff, length_ff, ptr_ff, end_ff;
   logic [7:0]       column_ff, removed_ff, char_ff;
   logic [15:0]      row_ff;
   logic [2:0]       op_ff;
   logic signed [AMT_W-1:0] amount_ff;
   logic [1:0]       status_ff;
   logic signed [11:0] disp_ff;
   logic             first_ff;

   // target of a move, one bit wider than both operands
   logic signed [POS_W+1:0] target;
   logic [POS_W-1:0] target_pos;
   logic             ram_we;
   logic [ADDR_W-1:0] ram_wa, ram_ra;
   logic [7:0]       ram_wd, ram_rd;
   logic [7:0]       adv_ch;
   logic             adv_en, view_clear;

   assign target = (op_ff == OP_MOVE_ABS)
      ? (POS_W+2)'(amount_ff)
      : $signed({2'b00, cursor_ff}) + (POS_W+2)'(amount_ff);
   assign target_pos = target[POS_W-1:0];

   assign stat.ov_full  = (cursor_ff >= POS_W'(CAPACITY));
   assign stat.ins_full = (length_ff >= POS_W'(CAPACITY));
   assign stat.del_bad  = (cursor_ff >= length_ff);
   assign stat.move_bad = target[POS_W+1] ||
                          (target > $signed({2'b00, length_ff}));
   assign stat.ins_more = (ptr_ff > cursor_ff);
   assign stat.del_more = ((ptr_ff + POS_W'(1)) < length_ff);
   assign stat.walk_more = (ptr_ff < end_ff);

   always_comb begin
      ram_we = 1'b0;
      ram_wa = cursor_ff[ADDR_W-1:0];
      ram_wd = char_ff;
      ram_ra = ptr_ff[ADDR_W-1:0];
      if (cmd.ov_commit || cmd.ins_commit) begin
         ram_we = 1'b1;
      end else if (cmd.ins_wr || cmd.del_wr) begin
         ram_we = 1'b1;
         ram_wa = ptr_ff[ADDR_W-1:0];
         ram_wd = ram_rd;
      end
      if (cmd.ins_rd) begin
         ram_ra = ADDR_W'(ptr_ff - POS_W'(1));
      end else if (cmd.del_rd) begin
         ram_ra = ADDR_W'(ptr_ff + POS_W'(1));
      end else if (cmd.del_setup) begin
         // character under the cursor, picked up by the first shift step
         ram_ra = cursor_ff[ADDR_W-1:0];
      end
   end

   tbce_ram #(.WIDTH(8), .DEPTH(CAPACITY)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   assign adv_en = cmd.ov_commit || cmd.ins_commit || cmd.walk_adv;
   assign adv_ch = cmd.walk_adv ? ram_rd : char_ff;
   assign view_clear = cmd.walk_setup &&
      (op_ff == OP_RECOUNT || target_pos < cursor_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         length_ff <= '0;
         column_ff <= '0;
         row_ff    <= '0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cmd.respond;
         if (view_clear) begin
            column_ff <= '0;
            row_ff    <= '0;
         end else if (adv_en) begin
            if (adv_ch == NEWLINE_CHAR || column_ff == 8'(line_width - 8'd1)) begin
               column_ff <= '0;
               if (row_ff != 16'hFFFF) row_ff <= row_ff + 16'd1;
            end else begin
               column_ff <= column_ff + 8'd1;
            end
         end
         if (cmd.ov_commit) begin
            cursor_ff <= cursor_ff + POS_W'(1);
            if (cursor_ff + POS_W'(1) > length_ff) length_ff <= cursor_ff + POS_W'(1);
         end
         if (cmd.ins_commit) begin
            cursor_ff <= cursor_ff + POS_W'(1);
            length_ff <= length_ff + POS_W'(1);
         end
         if (cmd.del_commit) length_ff <= length_ff - POS_W'(1);
         if (cmd.walk_commit && op_ff != OP_RECOUNT) cursor_ff <= end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff     <= op;
         char_ff   <= char_in;
         amount_ff <= amount;
         status_ff <= ST_DONE;
         disp_ff   <= '0;
         removed_ff <= '0;
      end
      if (cmd.ins_setup) ptr_ff <= length_ff;
      if (cmd.ins_wr) ptr_ff <= ptr_ff - POS_W'(1);
      if (cmd.del_setup) begin
         ptr_ff   <= cursor_ff;
         first_ff <= 1'b1;
      end
      if (cmd.del_rd || cmd.del_commit) begin
         if (first_ff) removed_ff <= ram_rd;
         first_ff <= 1'b0;
      end
      if (cmd.del_wr) ptr_ff <= ptr_ff + POS_W'(1);
      if (cmd.walk_setup) begin
         if (op_ff == OP_RECOUNT) begin
            ptr_ff <= '0;
            end_ff <= cursor_ff;
         end else begin
            ptr_ff <= (target_pos < cursor_ff) ? '0 : cursor_ff;
            end_ff <= target_pos;
            if (op_ff == OP_MOVE_ABS) begin
               disp_ff <= 12'(target_pos) - 12'(cursor_ff);
            end
         end
      end
      if (cmd.walk_adv) ptr_ff <= ptr_ff + POS_W'(1);
      // refusals detected at decide
      if (cmd.respond) begin
      end
   end

   // status decided once in the decide cycle, held until response
   logic [1:0] status_in;
   always_comb begin
      status_in = ST_DONE;
      priority case (op_ff)
         OP_OVERWRITE: if (stat.ov_full) status_in = ST_FULL;
         OP_INSERT:    if (stat.ins_full) status_in = ST_FULL;
         OP_DELETE:    if (stat.del_bad) status_in = ST_REFUSED;
         OP_MOVE_REL,
         OP_MOVE_ABS:  if (stat.move_bad) status_in = ST_REFUSED;
         default:      status_in = ST_DONE;
      endcase
   end

   logic decide_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         decide_ff <= 1'b0;
      end else begin
         decide_ff <= cmd.latch_req;
      end
      if (decide_ff) begin
         rsp_status <= status_in;
      end
   end

   assign rsp_removed_char = removed_ff;
   assign rsp_cursor_pos   = 11'(cursor_ff);
   assign rsp_text_length  = 11'(length_ff);
   assign rsp_view_column  = column_ff;
   assign rsp_view_row     = row_ff;
   assign rsp_displacement = disp_ff;

endmodule

/* sv/text_buffer_cursor_engine_core.sv */
// flow: overwrite, refusals and unused codes go from decide straight to respond; insert,
// delete, moves and recount then run a read state and a write or advance state per
// shifted or walked character; one request at a time, a new start is taken only while
// idle; results appear for one cycle and cannot be stalled
// reset: synchronous, clears cursor, length, view and sets line width to 80;
// store contents are undefined until written, no clearing pass
module text_buffer_cursor_engine_core
   import tbce_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_op,
   input  logic [7:0]         req_char_in,
   input  logic signed [11:0] req_amount,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_removed_char,
   output logic [10:0]        rsp_cursor_pos,
   output logic [10:0]        rsp_text_length,
   output logic [7:0]         rsp_view_column,
   output logic [15:0]        rsp_view_row,
   output logic signed [11:0] rsp_displacement,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_line_width
);

   cmd_type  cmd;
   stat_type stat;
   logic [7:0] line_width_ff;

   // line width register, always writable; applies on the next view advance
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RESET;
      end else if (csr_valid) begin
         line_width_ff <= csr_line_width;
      end
   end

   // sequencer: decides the operation and steps the shift or walk loop
   tbce_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .op    (req_op),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   // cursor, length, view counters and the character store
   tbce_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .op               (req_op),
      .char_in          (req_char_in),
      .amount           (req_amount),
      .line_width       (line_width_ff),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_removed_char (rsp_removed_char),
      .rsp_cursor_pos   (rsp_cursor_pos),
      .rsp_text_length  (rsp_text_length),
      .rsp_view_column  (rsp_view_column),
      .rsp_view_row     (rsp_view_row),
      .rsp_displacement (rsp_displacement)
   );

endmodule

/* tb/tb_text_buffer_cursor_engine_core.sv */
module tb_text_buffer_cursor_engine_core;
   import tbce_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 20000;

   typedef struct {
      logic [2:0]         op;
      logic [7:0]         ch;
      logic signed [11:0] amount;
      bit                 is_cfg;   // line width write instead of a request
      bit                 drain;    // hold off until every result has come
      logic [7:0]         width;
   } edit_req_t;

   typedef struct {
      logic [1:0]         status;
      logic [7:0]         removed;
      logic [10:0]        cursor;
      logic [10:0]        length;
      logic [7:0]         column;
      logic [15:0]        row;
      logic signed [11:0] disp;
   } edit_rsp_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic [2:0] req_op = '0;
   logic [7:0] req_char_in = '0;
   logic signed [11:0] req_amount = '0;
   logic csr_valid = 1'b0;
   logic [7:0] csr_line_width = '0;
   logic busy, rsp_valid, csr_ready;
   logic [1:0] rsp_status;
   logic [7:0] rsp_removed_char, rsp_view_column;
   logic [10:0] rsp_cursor_pos, rsp_text_length;
   logic [15:0] rsp_view_row;
   logic signed [11:0] rsp_displacement;

   text_buffer_cursor_engine_core dut (.*);

   always #10 clock = ~clock;

   // shadow copy of the editor state
   logic [7:0]  shadow_text [CAPACITY];
   int          sh_cursor, sh_length, sh_column, sh_row;
   logic [7:0]  sh_width;

   edit_req_t   pending_reqs[$];
   edit_rsp_t   expected_rsps[$];
   int          error_count;
   int          idle_cycles;
   int          gap_left;

   // one character step of the view
   function automatic void view_step(logic [7:0] c);
      logic [7:0] last_col;
      last_col = sh_width - 8'd1;
      if (c == NEWLINE_CHAR || sh_column == last_col) begin
         sh_column = 0;
         if (sh_row < 65535) sh_row++;
      end else begin
         sh_column = (sh_column + 1) & 8'hFF;
      end
   endfunction

   function automatic void view_rescan(int from, int upto);
      for (int i = from; i < upto && i < CAPACITY; i++) view_step(shadow_text[i]);
   endfunction

   function automatic void cursor_goto(int target);
      if (target < sh_cursor) begin
         sh_column = 0;
         sh_row = 0;
         view_rescan(0, target);
      end else begin
         view_rescan(sh_cursor, target);
      end
      sh_cursor = target;
   endfunction

   // work out the response of one accepted request and update the shadow
   function automatic edit_rsp_t edit_apply(edit_req_t r);
      edit_rsp_t e;
      int tgt, amt;
      e.status = ST_DONE;
      e.removed = '0;
      e.disp = '0;
      amt = int'(r.amount);
      case (r.op)
         OP_OVERWRITE: begin
            if (sh_cursor >= CAPACITY) e.status = ST_FULL;
            else begin
               shadow_text[sh_cursor] = r.ch;
               sh_cursor++;
               if (sh_cursor > sh_length) sh_length = sh_cursor;
               view_step(r.ch);
            end
         end
         OP_INSERT: begin
            if (sh_length >= CAPACITY) e.status = ST_FULL;
            else begin
               for (int i = sh_length; i > sh_cursor; i--) shadow_text[i] = shadow_text[i-1];
               shadow_text[sh_cursor] = r.ch;
               sh_cursor++;
               sh_length++;
               view_step(r.ch);
            end
         end
         OP_DELETE: begin
            if (sh_cursor >= sh_length) e.status = ST_REFUSED;
            else begin
               e.removed = shadow_text[sh_cursor];
               for (int i = sh_cursor; i < sh_length - 1; i++) shadow_text[i] = shadow_text[i+1];
               sh_length--;
            end
         end
         OP_MOVE_REL: begin
            tgt = sh_cursor + amt;
            if (tgt < 0 || tgt > sh_length) e.status = ST_REFUSED;
            else cursor_goto(tgt);
         end
         OP_MOVE_ABS: begin
            if (amt < 0 || amt > sh_length) e.status = ST_REFUSED;
            else begin
               e.disp = 12'(amt - sh_cursor);
               cursor_goto(amt);
            end
         end
         OP_RECOUNT: begin
            sh_column = 0;
            sh_row = 0;
            view_rescan(0, sh_cursor);
         end
         default: ;
      endcase
      e.cursor = 11'(sh_cursor);
      e.length = 11'(sh_length);
      e.column = 8'(sh_column);
      e.row = 16'(sh_row);
      return e;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   task automatic push_edit(logic [2:0] op, logic [7:0] ch, int amount);
      edit_req_t r;
      r = '{op: op, ch: ch, amount: 12'(amount), is_cfg: 0, drain: 0, width: 0};
      pending_reqs.push_back(r);
   endtask

   task automatic push_width(logic [7:0] w);
      edit_req_t r;
      r = '{op: 0, ch: 0, amount: 0, is_cfg: 1, drain: 1, width: w};
      pending_reqs.push_back(r);
   endtask

   task automatic push_pause();
      edit_req_t r;
      r = '{op: 0, ch: 0, amount: 0, is_cfg: 0, drain: 1, width: 0};
      pending_reqs.push_back(r);
   endtask

   // mostly short gaps, a few long ones, sometimes none for a stretch
   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // any 12-bit signed amount
   function automatic int rand_amount();
      return int'($urandom_range(0, 4095)) - 2048;
   endfunction

   // random request biased to keep the cursor inside the text
   task automatic push_random();
      int p;
      logic [7:0] c;
      p = $urandom_range(0, 99);
      c = ($urandom_range(0, 5) == 0) ? NEWLINE_CHAR : 8'($urandom);
      if (p < 25) push_edit(OP_INSERT, c, rand_amount());
      else if (p < 45) push_edit(OP_OVERWRITE, c, rand_amount());
      else if (p < 60) push_edit(OP_DELETE, 8'($urandom), rand_amount());
      else if (p < 75) push_edit(OP_MOVE_REL, 8'($urandom),
                                 ($urandom_range(0, 9) == 0) ? rand_amount()
                                 : int'($urandom_range(0, 60)) - 40);
      else if (p < 88) push_edit(OP_MOVE_ABS, 8'($urandom),
                                 ($urandom_range(0, 9) == 0) ? rand_amount()
                                 : int'($urandom_range(0, 120)));
      else if (p < 96) push_edit(OP_RECOUNT, 8'($urandom), rand_amount());
      else push_edit(3'($urandom_range(6, 7)), 8'($urandom), rand_amount());
   endtask

   // accept tracking done on the rising edge, driving on the falling edge
   bit req_taken, csr_taken;

   always @(posedge clock) begin
      req_taken <= !reset && start && !busy;
      csr_taken <= !reset && csr_valid && csr_ready;
      if (!reset) begin
         if (start && !busy) begin
            expected_rsps.push_back(edit_apply('{op: req_op, ch: req_char_in,
                                    amount: req_amount, is_cfg: 0, drain: 0, width: 0}));
         end
         if (csr_valid && csr_ready) begin
            sh_width = csr_line_width;
         end
      end
   end

   // driver: requests and register writes change at the falling edge
   always @(negedge clock) begin
      edit_req_t r;
      bit launch_req, launch_csr;
      launch_req = 1'b0;
      launch_csr = 1'b0;
      if (!reset) begin
         if (!(start && !req_taken) && !(csr_valid && !csr_taken)) begin
            if (gap_left > 0) gap_left--;
            else if (pending_reqs.size() > 0) begin
               r = pending_reqs[0];
               if (r.drain) begin
                  // idle wait; let any late store activity settle first
                  if (expected_rsps.size() == 0 && !busy) begin
                     if (r.is_cfg) begin
                        csr_line_width <= r.width;
                        launch_csr = 1'b1;
                     end
                     void'(pending_reqs.pop_front());
                     gap_left = 4;
                  end
               end else begin
                  req_op <= r.op;
                  req_char_in <= r.ch;
                  req_amount <= r.amount;
                  launch_req = 1'b1;
                  void'(pending_reqs.pop_front());
                  gap_left = pick_gap();
               end
            end
         end
         if (launch_req) start <= 1'b1;
         else if (req_taken) start <= 1'b0;
         if (launch_csr) csr_valid <= 1'b1;
         else if (csr_taken) csr_valid <= 1'b0;
      end
   end

   // monitor: one result per strobe, compared with the oldest expectation
   always @(posedge clock) begin
      edit_rsp_t e;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $display("unexpected response");
            error_count++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_status !== e.status) report_mismatch("status", rsp_status, e.status);
            if (rsp_removed_char !== e.removed)
               report_mismatch("removed_char", rsp_removed_char, e.removed);
            if (rsp_cursor_pos !== e.cursor)
               report_mismatch("cursor_pos", rsp_cursor_pos, e.cursor);
            if (rsp_text_length !== e.length)
               report_mismatch("text_length", rsp_text_length, e.length);
            if (rsp_view_column !== e.column)
               report_mismatch("view_column", rsp_view_column, e.column);
            if (rsp_view_row !== e.row) report_mismatch("view_row", rsp_view_row, e.row);
            if (rsp_displacement !== e.disp)
               report_mismatch("displacement", rsp_displacement, e.disp);
         end
      end
   end

   // watchdog on cycles with nothing accepted
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[text_buffer_cursor_engine_core] ERROR");
            $finish;
         end
      end
   end

   initial begin
      sh_cursor = 0; sh_length = 0; sh_column = 0; sh_row = 0;
      sh_width = LINE_WIDTH_RESET;
      error_count = 0; gap_left = 0;

      // directed: refusals on empty text, then fill and walk edge cases
      push_edit(OP_DELETE, 8'h00, 0);
      push_edit(OP_MOVE_REL, 8'h00, -1);
      push_edit(OP_MOVE_ABS, 8'h00, 2047);
      push_edit(OP_MOVE_ABS, 8'h00, -2048);
      push_edit(OP_INSERT, 8'hFF, 0);
      push_edit(OP_INSERT, NEWLINE_CHAR, 0);
      push_edit(OP_OVERWRITE, 8'h00, 0);
      push_edit(OP_OVERWRITE, 8'hAA, 12'h555);
      push_edit(OP_MOVE_ABS, 8'h55, 1);
      push_edit(OP_DELETE, 8'h00, 0);
      push_edit(OP_MOVE_REL, 8'h00, 2);
      push_edit(OP_MOVE_REL, 8'h00, 1);
      push_edit(OP_RECOUNT, 8'h00, 0);
      push_edit(3'd6, 8'h12, 5);
      push_edit(3'd7, 8'h34, -5);
      push_edit(OP_MOVE_ABS, 8'h00, 0);
      push_pause();
      push_width(8'd1);
      for (int i = 0; i < 4; i++) push_edit(OP_OVERWRITE, 8'h41, 0);
      push_edit(OP_RECOUNT, 8'h00, 0);
      push_width(8'd0);
      push_edit(OP_RECOUNT, 8'h00, 0);

      // random phases with several line widths, extremes among them
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: push_width(8'd255);
            1: push_width(8'd3);
            2: push_width(8'($urandom_range(1, 255)));
            3: push_width(8'd80);
            default: push_width(8'($urandom));
         endcase
         for (int i = 0; i < 90; i++) push_random();
         push_edit(OP_RECOUNT, 8'h00, 0);
      end

      // end of text and out of range moves
      push_width(8'd255);
      push_edit(OP_MOVE_ABS, 8'h00, 0);
      push_edit(OP_OVERWRITE, 8'h7E, 0);
      push_edit(OP_MOVE_ABS, 8'h00, 1024);
      push_edit(OP_MOVE_REL, 8'h00, -1024);
      push_edit(OP_DELETE, 8'h00, 0);
      push_edit(OP_MOVE_ABS, 8'h00, 1023);
      push_edit(OP_OVERWRITE, 8'h31, 0);

      // deassert reset on a falling edge
      repeat (11) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      wait (pending_reqs.size() == 0 && !start && !csr_valid);
      wait (expected_rsps.size() == 0);
      repeat (50) @(posedge clock);
      if (error_count == 0) $display("[text_buffer_cursor_engine_core] OK");
      else $display("[text_buffer_cursor_engine_core] ERROR");
      $finish;
   end
endmodule
